>>> design/mcg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_pkg
// Shared widths, action codes and the job record passed from the front end
// to the pixel emitter of the midpoint circle generator.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int CoordBits = 16;
  localparam int OffBits   = 16;
  localparam int RadBits   = 15;
  localparam int ColorBits = 16;
  localparam int DecBits   = 20;

  // job queue, depth is a power of two
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = $clog2(QueueDepth);

  localparam int PixPerStep = 8;
  localparam int PixIdxBits = $clog2(PixPerStep);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef struct packed {
    logic                 idle;
    logic                 done;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [OffBits-1:0]   a;
    logic [OffBits-1:0]   b;
    logic [ColorBits-1:0] color;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

>>> design/mcg_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_cmd_if
// Command channel: load or step beats with circle parameters.
// ----------------------------------------------------------------------------
interface mcg_cmd_if;

  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [14:0] radius;
  logic [15:0] color;

  modport source (output valid, output action, output center_x, output center_y,
                  output radius, output color, input ready);
  modport sink (input valid, input action, input center_x, input center_y,
                input radius, input color, output ready);

endinterface

`default_nettype wire

>>> design/mcg_pix_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_pix_if
// Pixel channel: one pixel (or one idle marker) per beat.
// ----------------------------------------------------------------------------
interface mcg_pix_if;

  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [15:0] pixel_color;
  logic        pixel_valid;
  logic        last_of_step;
  logic        circle_done;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  output pixel_valid, output last_of_step, output circle_done,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input pixel_color,
                input pixel_valid, input last_of_step, input circle_done,
                output ready);

endinterface

`default_nettype wire

>>> design/mcg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_front
// Takes command beats, holds the circle state and advances the decision
// variable on each step of a loaded circle; every step is one emitter job.
// ----------------------------------------------------------------------------
module mcg_front import mcg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mcg_cmd_if.sink   cmd,
  output job_t      q_job,
  output logic      q_push,
  input  q_stat_t   q_stat
);

  logic [CoordBits-1:0] center_col;
  logic [CoordBits-1:0] center_row;
  logic [ColorBits-1:0] draw_color;
  logic [OffBits-1:0]   minor_offset;
  logic [OffBits-1:0]   major_offset;
  logic [DecBits-1:0]   decision;
  logic                 active;

  logic                 take;
  logic [OffBits:0]     na;
  logic [OffBits+1:0]   na_s;
  logic [OffBits+1:0]   nb_s;
  logic [DecBits-1:0]   dec_next;
  logic                 done;

  assign cmd.ready = !q_stat.full;
  assign take      = cmd.valid && cmd.ready;

  // midpoint update
  always_comb begin
    na   = {1'b0, minor_offset} + (OffBits+1)'(1);
    na_s = {1'b0, na};
    if (decision[DecBits-1]) begin
      nb_s     = {2'b00, major_offset};
      dec_next = decision + DecBits'({na, 2'b00}) + DecBits'(6);
    end else begin
      nb_s     = {2'b00, major_offset} - (OffBits+2)'(1);
      dec_next = decision + DecBits'(10)
               + DecBits'({na_s - {2'b00, major_offset}, 2'b00});
    end
    done = $signed(na_s) > $signed(nb_s);
  end

  always_comb begin
    q_push      = take && (cmd.action == ACT_STEP);
    q_job.idle  = !active;
    q_job.done  = active ? done : 1'b1;
    q_job.x     = center_col;
    q_job.y     = center_row;
    q_job.a     = minor_offset;
    q_job.b     = major_offset;
    q_job.color = draw_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      minor_offset <= '0;
      major_offset <= '0;
      decision     <= '0;
      active       <= 1'b0;
    end else if (take) begin
      if (cmd.action == ACT_LOAD) begin
        minor_offset <= '0;
        major_offset <= OffBits'(cmd.radius);
        decision     <= DecBits'(3) - DecBits'({cmd.radius, 1'b0});
        active       <= 1'b1;
      end else if (active) begin
        minor_offset <= na[OffBits-1:0];
        major_offset <= nb_s[OffBits-1:0];
        decision     <= dec_next;
        if (done) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.action == ACT_LOAD) begin
      center_col <= cmd.center_x[CoordBits-1:0];
      center_row <= cmd.center_y[CoordBits-1:0];
      draw_color <= cmd.color;
    end
  end

endmodule

`default_nettype wire

>>> design/mcg_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_queue
// Short job queue between the front end and the pixel emitter.
// ----------------------------------------------------------------------------
module mcg_queue import mcg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_stat_t   stat
);

  job_t                entries [QueueDepth];
  logic [QPtrBits-1:0] wr_ptr;
  logic [QPtrBits-1:0] rd_ptr;
  logic [QPtrBits:0]   count;
  logic                do_push;
  logic                do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QPtrBits+1)'(QueueDepth));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPtrBits'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPtrBits+1)'(1);
        2'b01:   count <= count - (QPtrBits+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> design/mcg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_back
// Pixel emitter: expands one job into its eight symmetric pixels, or one
// idle marker, through a registered output stage.
// ----------------------------------------------------------------------------
module mcg_back import mcg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  job_t      head,
  input  q_stat_t   q_stat,
  output logic      pop,
  mcg_pix_if.source pix
);

  job_t                 job;
  logic                 busy;
  logic [PixIdxBits-1:0] idx;
  logic                 out_valid;

  logic                 advance;
  logic                 last;
  logic [CoordBits-1:0] off_x;
  logic [CoordBits-1:0] off_y;
  logic [CoordBits-1:0] px;
  logic [CoordBits-1:0] py;

  assign advance = !out_valid || pix.ready;
  assign last    = job.idle || (idx == PixIdxBits'(PixPerStep - 1));
  assign pop     = !q_stat.empty && (!busy || (advance && last));
  assign pix.valid = out_valid;

  // idx bit 2 swaps the offsets, bit 0 mirrors x, bit 1 mirrors y
  always_comb begin
    off_x = idx[2] ? job.a[CoordBits-1:0] : job.b[CoordBits-1:0];
    off_y = idx[2] ? job.b[CoordBits-1:0] : job.a[CoordBits-1:0];
    px    = idx[0] ? job.x - off_x : job.x + off_x;
    py    = idx[1] ? job.y - off_y : job.y + off_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      // a new job is popped in the same cycle the previous one's last beat is loaded into the output register
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (advance && busy) begin
        idx <= idx + PixIdxBits'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (advance && busy) begin
      pix.pixel_x      <= job.idle ? 16'd0 : 16'(px);
      pix.pixel_y      <= job.idle ? 16'd0 : 16'(py);
      pix.pixel_color  <= job.idle ? 16'd0 : 16'(job.color);
      pix.pixel_valid  <= !job.idle;
      pix.last_of_step <= last;
      pix.circle_done  <= job.done;
    end
  end

endmodule

`default_nettype wire

>>> design/midpoint_circle_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_circle_generator
// Midpoint circle rasterizer: load a circle, then step it octant by octant.
// ----------------------------------------------------------------------------
// A load beat latches center, radius and color and gives no output. Each step
// beat gives eight pixel beats, the symmetric points of the current offsets,
// the eighth marked last_of_step; circle_done is set on every beat of the
// step that finishes the circle. A step with no circle loaded gives one beat
// with pixel_valid low and last_of_step and circle_done high. The pixel
// emitter sends one beat per cycle unless a low pix.ready holds it back; the
// command side takes one beat per cycle until the two-entry job queue in
// front of the emitter fills, so loads and the next steps are taken while
// earlier pixels are still going out.
// ----------------------------------------------------------------------------
module midpoint_circle_generator import mcg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mcg_cmd_if.sink   cmd,
  mcg_pix_if.source pix
);

  job_t    push_job;
  logic    push;
  job_t    head;
  logic    pop;
  q_stat_t q_stat;

  mcg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .q_job  (push_job),
    .q_push (push),
    .q_stat (q_stat)
  );

  mcg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  mcg_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .pix    (pix)
  );

endmodule

`default_nettype wire
